// File: sv/sts_pkg.sv
`default_nettype none
package sts_pkg;

    localparam int unsigned KwCount = 22;
    localparam int unsigned KwTextLen = 7;

    localparam logic [5:0] K_IDENT   = 6'd0;
    localparam logic [5:0] K_INT     = 6'd1;
    localparam logic [5:0] K_FLOAT   = 6'd2;
    localparam logic [5:0] K_STR     = 6'd3;
    localparam logic [5:0] K_KW      = 6'd4;
    localparam logic [5:0] K_LPAREN  = 6'd26;
    localparam logic [5:0] K_RPAREN  = 6'd27;
    localparam logic [5:0] K_COMMA   = 6'd28;
    localparam logic [5:0] K_SEMI    = 6'd29;
    localparam logic [5:0] K_DOT     = 6'd30;
    localparam logic [5:0] K_PLUS    = 6'd31;
    localparam logic [5:0] K_MINUS   = 6'd32;
    localparam logic [5:0] K_STAR    = 6'd33;
    localparam logic [5:0] K_EQ      = 6'd34;
    localparam logic [5:0] K_LT      = 6'd35;
    localparam logic [5:0] K_LEQ     = 6'd36;
    localparam logic [5:0] K_NEQ     = 6'd37;
    localparam logic [5:0] K_GT      = 6'd38;
    localparam logic [5:0] K_GEQ     = 6'd39;
    localparam logic [5:0] K_UNKNOWN = 6'd40;
    localparam logic [5:0] K_EOF     = 6'd41;

    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;

    // Keyword text, right aligned: the first letter sits in the highest used byte.
    function automatic logic [55:0] kw_text(input logic [4:0] idx);
        logic [55:0] t;
        case (idx)
            5'd0:    t = 56'("CREATE");
            5'd1:    t = 56'("TABLE");
            5'd2:    t = 56'("DROP");
            5'd3:    t = 56'("INSERT");
            5'd4:    t = 56'("INTO");
            5'd5:    t = 56'("VALUES");
            5'd6:    t = 56'("SELECT");
            5'd7:    t = 56'("FROM");
            5'd8:    t = 56'("WHERE");
            5'd9:    t = 56'("UPDATE");
            5'd10:   t = 56'("SET");
            5'd11:   t = 56'("DELETE");
            5'd12:   t = 56'("PRIMARY");
            5'd13:   t = 56'("KEY");
            5'd14:   t = 56'("INT");
            5'd15:   t = 56'("BIGINT");
            5'd16:   t = 56'("VARCHAR");
            5'd17:   t = 56'("FLOAT");
            5'd18:   t = 56'("AND");
            5'd19:   t = 56'("OR");
            5'd20:   t = 56'("NOT");
            5'd21:   t = 56'("NULL");
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic logic [2:0] kw_len(input logic [4:0] idx);
        logic [2:0] l;
        case (idx)
            5'd0, 5'd3, 5'd5, 5'd6, 5'd9, 5'd11, 5'd15: l = 3'd6;
            5'd1, 5'd8, 5'd17:                           l = 3'd5;
            5'd2, 5'd4, 5'd7, 5'd21:                     l = 3'd4;
            5'd10, 5'd13, 5'd14, 5'd18, 5'd20:           l = 3'd3;
            5'd12, 5'd16:                                l = 3'd7;
            5'd19:                                       l = 3'd2;
            default:                                     l = 3'd0;
        endcase
        return l;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == 8'h5F);
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) ? c - 8'h20 : c;
    endfunction

endpackage
`default_nettype wire

// File: sv/sql_token_scanner.sv
// The tokens of a taken word are found combinationally and registered in the output buffer.
// Throughput: one source byte per cycle while each byte yields at most one token and output
// is not stalled; a byte with two or three tokens holds input until its last one leaves.
// Reset (synchronous, active low): scanner idle, offset 0, line 1, output buffer empty.
`default_nettype none
module sql_token_scanner #(
    parameter int unsigned OFFSET_BITS = 24,
    parameter int unsigned LINE_BITS = 20,
    parameter int unsigned KEYWORD_MAX_LEN = 7
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_stall,
    input  wire logic [7:0]              i_data_byte,
    input  wire logic                    i_has_byte,
    input  wire logic                    i_end_of_source,
    output logic                         o_valid,
    input  wire logic                    i_stall,
    output logic [5:0]                   o_token_kind,
    output logic [OFFSET_BITS-1:0]       o_start_offset,
    output logic [OFFSET_BITS-1:0]       o_span_length,
    output logic [LINE_BITS-1:0]         o_line_number,
    output logic                         o_last_of_run
);
    import sts_pkg::*;

    logic                           accept;
    logic                           free;
    logic [1:0]                     count;
    logic [2:0][5:0]                kind;
    logic [2:0][OFFSET_BITS-1:0]    start;
    logic [2:0][OFFSET_BITS-1:0]    span;
    logic [2:0][LINE_BITS-1:0]      line;

    assign o_stall = !free;
    assign accept = i_valid && free;

    sts_core #(
        .OFFSET_BITS(OFFSET_BITS),
        .LINE_BITS(LINE_BITS),
        .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)
    ) u_core (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_accept(accept),
        .i_data_byte(i_data_byte),
        .i_has_byte(i_has_byte),
        .i_end_of_source(i_end_of_source),
        .o_count(count),
        .o_kind(kind),
        .o_start(start),
        .o_span(span),
        .o_line(line)
    );

    sts_out_buf #(
        .OFFSET_BITS(OFFSET_BITS),
        .LINE_BITS(LINE_BITS)
    ) u_out_buf (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_load(accept),
        .i_count(count),
        .i_kind(kind),
        .i_start(start),
        .i_span(span),
        .i_line(line),
        .o_free(free),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_token_kind(o_token_kind),
        .o_start_offset(o_start_offset),
        .o_span_length(o_span_length),
        .o_line_number(o_line_number),
        .o_last_of_run(o_last_of_run)
    );

    // The end of source always produces at least the Eof word.
    a_eof_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_end_of_source |=> o_valid)
        else $error("end of source gave no token");

    a_eof_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_token_kind == K_EOF |-> o_last_of_run && o_span_length == '0)
        else $error("Eof token malformed");

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> !o_valid || (o_last_of_run && !i_stall))
        else $error("item accepted over pending tokens");

endmodule
`default_nettype wire

// File: sv/sts_kw_match.sv
`default_nettype none
module sts_kw_match #(
    parameter int unsigned KEYWORD_MAX_LEN = 7,
    parameter int unsigned WLEN_BITS = 4
) (
    input  wire logic [KEYWORD_MAX_LEN-1:0][7:0] i_word,
    input  wire logic [WLEN_BITS-1:0]            i_word_len,
    output logic [5:0]                           o_kind
);
    import sts_pkg::*;

    logic [KwCount-1:0] hit;

    always_comb begin
        logic [55:0] txt;
        logic [2:0]  len;
        for (int i = 0; i < KwCount; i++) begin
            txt = kw_text(5'(i));
            len = kw_len(5'(i));
            hit[i] = (i_word_len == WLEN_BITS'(len));
            for (int j = 0; j < KwTextLen; j++) begin
                if (j < int'(len)) begin
                    hit[i] = hit[i] && (i_word[j] == txt[(int'(len) - 1 - j) * 8 +: 8]);
                end
            end
        end
    end

    always_comb begin
        o_kind = K_IDENT;
        for (int i = KwCount - 1; i >= 0; i--) begin
            if (hit[i]) begin
                o_kind = K_KW + 6'(i);
            end
        end
    end

endmodule
`default_nettype wire

// File: sv/sts_core.sv
`default_nettype none
module sts_core #(
    parameter int unsigned OFFSET_BITS = 24,
    parameter int unsigned LINE_BITS = 20,
    parameter int unsigned KEYWORD_MAX_LEN = 7
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  wire logic [7:0]                    i_data_byte,
    input  wire logic                          i_has_byte,
    input  wire logic                          i_end_of_source,
    output logic [1:0]                         o_count,
    output logic [2:0][5:0]                    o_kind,
    output logic [2:0][OFFSET_BITS-1:0]        o_start,
    output logic [2:0][OFFSET_BITS-1:0]        o_span,
    output logic [2:0][LINE_BITS-1:0]          o_line
);
    import sts_pkg::*;

    localparam int unsigned WLEN_BITS = $clog2(KEYWORD_MAX_LEN + 2);
    localparam logic [OFFSET_BITS-1:0] OFF_MAX = '1;
    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;

    typedef enum logic [3:0] {
        M_IDLE, M_WORD, M_INT, M_FRAC, M_STR, M_ESC, M_COMMENT,
        M_LT, M_GT, M_BANG, M_MINUS
    } t_mode;

    t_mode                             r_mode, n_mode;
    logic [OFFSET_BITS-1:0]            r_start, n_start;
    logic [OFFSET_BITS-1:0]            r_off, n_off;
    logic [OFFSET_BITS-1:0]            r_span, n_span;
    logic [LINE_BITS-1:0]              r_line, n_line;
    logic [WLEN_BITS-1:0]              r_wlen, n_wlen;
    logic [KEYWORD_MAX_LEN-1:0][7:0]   r_wbuf, n_wbuf;
    logic [5:0]                        word_kind;
    logic [OFFSET_BITS-1:0]            span_inc;

    assign span_inc = (r_span == OFF_MAX) ? r_span : r_span + 1'b1;

    // Word buffer: word bytes grow it; letters and _ open it, not in strings/comments.
    always_comb begin
        n_wbuf = r_wbuf;
        n_wlen = r_wlen;
        if (i_has_byte && is_word(i_data_byte)) begin
            if (r_mode == M_WORD) begin
                if (r_wlen < WLEN_BITS'(KEYWORD_MAX_LEN)) begin
                    n_wbuf[r_wlen[$clog2(KEYWORD_MAX_LEN)-1:0]] = to_upper(i_data_byte);
                end
                if (r_wlen <= WLEN_BITS'(KEYWORD_MAX_LEN)) begin
                    n_wlen = r_wlen + 1'b1;
                end
            end else if (!is_digit(i_data_byte) &&
                         (r_mode == M_IDLE || r_mode == M_INT || r_mode == M_FRAC ||
                          r_mode == M_LT || r_mode == M_GT || r_mode == M_BANG ||
                          r_mode == M_MINUS)) begin
                n_wbuf[0] = to_upper(i_data_byte);
                n_wlen = WLEN_BITS'(1);
            end
        end
    end

    sts_kw_match #(
        .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN),
        .WLEN_BITS(WLEN_BITS)
    ) u_kw_match (
        .i_word(n_wbuf),
        .i_word_len(n_wlen),
        .o_kind(word_kind)
    );

    always_comb begin
        logic [7:0]           c;
        logic                 do_close;
        logic                 do_idle;
        logic                 pend;
        logic [5:0]           pkind;
        logic [5:0]           k1;
        logic [LINE_BITS-1:0] line_after;
        c = i_data_byte;
        do_close = 1'b0;
        do_idle = 1'b0;
        pend = 1'b0;
        pkind = K_IDENT;
        k1 = K_UNKNOWN;
        n_mode = r_mode;
        n_start = r_start;
        n_span = r_span;
        n_off = r_off;
        n_line = r_line;
        o_count = 2'd0;
        o_kind = '0;
        o_start = '0;
        o_span = '0;
        o_line = '0;

        if (i_has_byte) begin
            unique case (r_mode)
                M_WORD: begin
                    if (is_word(c)) n_span = span_inc;
                    else begin
                        do_close = 1'b1;
                        do_idle = 1'b1;
                    end
                end
                M_INT: begin
                    if (is_digit(c)) n_span = span_inc;
                    else if (c == 8'h2E) begin
                        n_span = span_inc;
                        n_mode = M_FRAC;
                    end else begin
                        do_close = 1'b1;
                        do_idle = 1'b1;
                    end
                end
                M_FRAC: begin
                    if (is_digit(c)) n_span = span_inc;
                    else begin
                        do_close = 1'b1;
                        do_idle = 1'b1;
                    end
                end
                M_STR: begin
                    n_span = span_inc;
                    if (c == CH_BSLASH) n_mode = M_ESC;
                    else if (c == CH_QUOTE) begin
                        o_kind[o_count] = K_STR;
                        o_start[o_count] = r_start;
                        o_span[o_count] = span_inc;
                        o_line[o_count] = r_line;
                        o_count = o_count + 1'b1;
                        n_mode = M_IDLE;
                    end
                end
                M_ESC: begin
                    n_span = span_inc;
                    n_mode = M_STR;
                end
                M_COMMENT: begin
                    if (c == CH_NL) n_mode = M_IDLE;
                end
                M_LT, M_GT, M_BANG: begin
                    if (c == 8'h3D || (r_mode == M_LT && c == 8'h3E)) begin
                        n_span = span_inc;
                        o_kind[o_count] = (r_mode == M_LT) ? ((c == 8'h3D) ? K_LEQ : K_NEQ)
                                        : (r_mode == M_GT) ? K_GEQ : K_NEQ;
                        o_start[o_count] = r_start;
                        o_span[o_count] = span_inc;
                        o_line[o_count] = r_line;
                        o_count = o_count + 1'b1;
                        n_mode = M_IDLE;
                    end else begin
                        do_close = 1'b1;
                        do_idle = 1'b1;
                    end
                end
                M_MINUS: begin
                    if (c == 8'h2D) n_mode = M_COMMENT;
                    else begin
                        do_close = 1'b1;
                        do_idle = 1'b1;
                    end
                end
                default: do_idle = 1'b1;
            endcase

            if (do_close) begin
                unique case (r_mode)
                    M_WORD:  pkind = word_kind;
                    M_INT:   pkind = K_INT;
                    M_FRAC:  pkind = K_FLOAT;
                    M_LT:    pkind = K_LT;
                    M_GT:    pkind = K_GT;
                    M_BANG:  pkind = K_UNKNOWN;
                    M_MINUS: pkind = K_MINUS;
                    default: pkind = K_STR;
                endcase
                o_kind[o_count] = pkind;
                o_start[o_count] = r_start;
                o_span[o_count] = r_span;
                o_line[o_count] = r_line;
                o_count = o_count + 1'b1;
                n_mode = M_IDLE;
            end

            if (do_idle && !is_space(c)) begin
                n_start = r_off;
                n_span = OFFSET_BITS'(1);
                if (c == CH_QUOTE) n_mode = M_STR;
                else if (is_digit(c)) n_mode = M_INT;
                else if (is_alpha(c) || c == 8'h5F) n_mode = M_WORD;
                else begin
                    case (c)
                        8'h3C: n_mode = M_LT;
                        8'h3E: n_mode = M_GT;
                        8'h21: n_mode = M_BANG;
                        8'h2D: n_mode = M_MINUS;
                        default: begin
                            case (c)
                                8'h28:   k1 = K_LPAREN;
                                8'h29:   k1 = K_RPAREN;
                                8'h2C:   k1 = K_COMMA;
                                8'h3B:   k1 = K_SEMI;
                                8'h2E:   k1 = K_DOT;
                                8'h2B:   k1 = K_PLUS;
                                8'h2A:   k1 = K_STAR;
                                8'h3D:   k1 = K_EQ;
                                default: k1 = K_UNKNOWN;
                            endcase
                            o_kind[o_count] = k1;
                            o_start[o_count] = r_off;
                            o_span[o_count] = OFFSET_BITS'(1);
                            o_line[o_count] = r_line;
                            o_count = o_count + 1'b1;
                        end
                    endcase
                end
            end

            if (c == CH_NL && r_line != LINE_MAX) n_line = r_line + 1'b1;
            if (r_off != OFF_MAX) n_off = r_off + 1'b1;
        end

        line_after = n_line;
        if (i_end_of_source) begin
            unique case (n_mode)
                M_WORD:  begin pend = 1'b1; pkind = word_kind; end
                M_INT:   begin pend = 1'b1; pkind = K_INT;     end
                M_FRAC:  begin pend = 1'b1; pkind = K_FLOAT;   end
                M_STR,
                M_ESC:   begin pend = 1'b1; pkind = K_STR;     end
                M_LT:    begin pend = 1'b1; pkind = K_LT;      end
                M_GT:    begin pend = 1'b1; pkind = K_GT;      end
                M_BANG:  begin pend = 1'b1; pkind = K_UNKNOWN; end
                M_MINUS: begin pend = 1'b1; pkind = K_MINUS;   end
                default: pend = 1'b0;
            endcase
            if (pend) begin
                o_kind[o_count] = pkind;
                o_start[o_count] = n_start;
                o_span[o_count] = n_span;
                o_line[o_count] = line_after;
                o_count = o_count + 1'b1;
            end
            o_kind[o_count] = K_EOF;
            o_start[o_count] = n_off;
            o_span[o_count] = '0;
            o_line[o_count] = line_after;
            o_count = o_count + 1'b1;
            n_mode = M_IDLE;
            n_start = '0;
            n_off = '0;
            n_span = '0;
            n_line = LINE_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_start <= '0;
            r_off <= '0;
            r_span <= '0;
            r_line <= LINE_BITS'(1);
            r_wlen <= '0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_start <= n_start;
            r_off <= n_off;
            r_span <= n_span;
            r_line <= n_line;
            r_wlen <= i_end_of_source ? '0 : n_wlen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_wbuf <= n_wbuf;
        end
    end

endmodule
`default_nettype wire

// File: sv/sts_out_buf.sv
`default_nettype none
module sts_out_buf #(
    parameter int unsigned OFFSET_BITS = 24,
    parameter int unsigned LINE_BITS = 20
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_load,
    input  wire logic [1:0]                    i_count,
    input  wire logic [2:0][5:0]               i_kind,
    input  wire logic [2:0][OFFSET_BITS-1:0]   i_start,
    input  wire logic [2:0][OFFSET_BITS-1:0]   i_span,
    input  wire logic [2:0][LINE_BITS-1:0]     i_line,
    output logic                               o_free,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [5:0]                         o_token_kind,
    output logic [OFFSET_BITS-1:0]             o_start_offset,
    output logic [OFFSET_BITS-1:0]             o_span_length,
    output logic [LINE_BITS-1:0]               o_line_number,
    output logic                               o_last_of_run
);
    logic [1:0]                       r_left;
    logic [1:0]                       r_head;
    logic [2:0][5:0]                  r_kind;
    logic [2:0][OFFSET_BITS-1:0]      r_start;
    logic [2:0][OFFSET_BITS-1:0]      r_span;
    logic [2:0][LINE_BITS-1:0]        r_line;
    logic                             pop;

    assign o_valid = (r_left != 2'd0);
    assign pop = o_valid && !i_stall;
    // A new item may land as the last buffered word leaves.
    assign o_free = (r_left == 2'd0) || (r_left == 2'd1 && pop);

    assign o_token_kind = r_kind[r_head];
    assign o_start_offset = r_start[r_head];
    assign o_span_length = r_span[r_head];
    assign o_line_number = r_line[r_head];
    assign o_last_of_run = (r_left == 2'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= 2'd0;
            r_head <= 2'd0;
        end else if (i_load) begin
            r_left <= i_count;
            r_head <= 2'd0;
        end else if (pop) begin
            r_left <= r_left - 1'b1;
            r_head <= r_head + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_kind <= i_kind;
            r_start <= i_start;
            r_span <= i_span;
            r_line <= i_line;
        end
    end

endmodule
`default_nettype wire

// File: sim/sts_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module sts_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        i_stall_in,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_has_byte,
    input  wire logic        i_end_of_source,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [5:0]  i_token_kind,
    input  wire logic [23:0] i_start_offset,
    input  wire logic [23:0] i_span_length,
    input  wire logic [19:0] i_line_number,
    input  wire logic        i_last_of_run,
    output int               o_fail_count,
    output int               o_pending
);
    import sts_pkg::*;

    typedef enum logic [3:0] {
        SC_IDLE, SC_WORD, SC_INT, SC_FRAC, SC_STR, SC_ESC, SC_COMMENT,
        SC_LT, SC_GT, SC_BANG, SC_MINUS
    } t_scan;

    typedef struct packed {
        logic [5:0]  kind;
        logic [23:0] start;
        logic [23:0] span;
        logic [19:0] line;
        logic        last;
    } t_token;

    localparam logic [23:0] OffMax  = '1;
    localparam logic [19:0] LineMax = '1;
    localparam string KwNames[22] = '{
        "CREATE", "TABLE", "DROP", "INSERT", "INTO", "VALUES", "SELECT",
        "FROM", "WHERE", "UPDATE", "SET", "DELETE", "PRIMARY", "KEY", "INT",
        "BIGINT", "VARCHAR", "FLOAT", "AND", "OR", "NOT", "NULL"};

    t_scan       mode;
    logic [23:0] tok_start, offset, span;
    logic [19:0] line;
    logic [7:0]  word[7];
    int          word_len;
    t_token      expected_tokens[$];
    t_token      run_tokens[$];
    int          mismatches;

    assign o_fail_count = mismatches;
    assign o_pending = expected_tokens.size();

    function automatic logic [7:0] upcase(input logic [7:0] c);
        return (c >= "a" && c <= "z") ? c - 8'd32 : c;
    endfunction

    function automatic logic digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic letter(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    task automatic push_token(input logic [5:0] kind, input logic [23:0] st,
                              input logic [23:0] len);
        t_token t;
        t = '{kind: kind, start: st, span: len, line: line, last: 1'b0};
        run_tokens = {run_tokens, t};
    endtask

    function automatic logic [5:0] classify_word();
        string s;
        s = "";
        for (int i = 0; i < word_len && i < 7; i++) s = {s, string'(word[i])};
        if (word_len > 7) return K_IDENT;
        foreach (KwNames[i]) if (s == KwNames[i]) return K_KW + 6'(i);
        return K_IDENT;
    endfunction

    task automatic close_token();
        case (mode)
            SC_WORD:          push_token(classify_word(), tok_start, span);
            SC_INT:           push_token(K_INT, tok_start, span);
            SC_FRAC:          push_token(K_FLOAT, tok_start, span);
            SC_STR, SC_ESC:   push_token(K_STR, tok_start, span);
            SC_LT:            push_token(K_LT, tok_start, span);
            SC_GT:            push_token(K_GT, tok_start, span);
            SC_BANG:          push_token(K_UNKNOWN, tok_start, span);
            SC_MINUS:         push_token(K_MINUS, tok_start, span);
            default: ;
        endcase
        mode = SC_IDLE;
    endtask

    task automatic extend();
        if (span != OffMax) span++;
    endtask

    task automatic open_token(input logic [7:0] c);
        logic [5:0] k;
        if (c == " " || (c >= 8'd9 && c <= 8'd13)) return;
        tok_start = offset;
        span = 24'd1;
        if (c == CH_QUOTE) begin mode = SC_STR; return; end
        if (digit(c)) begin mode = SC_INT; return; end
        if (letter(c) || c == "_") begin
            word[0] = upcase(c);
            word_len = 1;
            mode = SC_WORD;
            return;
        end
        case (c)
            "<": begin mode = SC_LT; return; end
            ">": begin mode = SC_GT; return; end
            "!": begin mode = SC_BANG; return; end
            "-": begin mode = SC_MINUS; return; end
            "(": k = K_LPAREN;
            ")": k = K_RPAREN;
            ",": k = K_COMMA;
            ";": k = K_SEMI;
            ".": k = K_DOT;
            "+": k = K_PLUS;
            "*": k = K_STAR;
            "=": k = K_EQ;
            default: k = K_UNKNOWN;
        endcase
        push_token(k, tok_start, 24'd1);
    endtask

    task automatic scan_byte(input logic [7:0] c);
        case (mode)
            SC_WORD:
                if (letter(c) || digit(c) || c == "_") begin
                    extend();
                    if (word_len < 7) word[word_len] = upcase(c);
                    if (word_len <= 7) word_len++;
                end else begin
                    close_token(); open_token(c);
                end
            SC_INT:
                if (digit(c)) extend();
                else if (c == ".") begin extend(); mode = SC_FRAC; end
                else begin close_token(); open_token(c); end
            SC_FRAC:
                if (digit(c)) extend();
                else begin close_token(); open_token(c); end
            SC_STR: begin
                extend();
                if (c == CH_BSLASH) mode = SC_ESC;
                else if (c == CH_QUOTE) begin
                    push_token(K_STR, tok_start, span);
                    mode = SC_IDLE;
                end
            end
            SC_ESC: begin extend(); mode = SC_STR; end
            SC_COMMENT: if (c == CH_NL) mode = SC_IDLE;
            SC_LT:
                if (c == "=" || c == ">") begin
                    extend();
                    push_token(c == "=" ? K_LEQ : K_NEQ, tok_start, span);
                    mode = SC_IDLE;
                end else begin close_token(); open_token(c); end
            SC_GT, SC_BANG:
                if (c == "=") begin
                    extend();
                    push_token(mode == SC_GT ? K_GEQ : K_NEQ, tok_start, span);
                    mode = SC_IDLE;
                end else begin close_token(); open_token(c); end
            SC_MINUS:
                if (c == "-") mode = SC_COMMENT;
                else begin close_token(); open_token(c); end
            default: begin mode = SC_IDLE; open_token(c); end
        endcase
        if (c == CH_NL && line != LineMax) line++;
        if (offset != OffMax) offset++;
    endtask

    task automatic clear_scanner();
        mode = SC_IDLE;
        tok_start = '0;
        offset = '0;
        line = 20'd1;
        word_len = 0;
        span = '0;
    endtask

    task automatic predict_word(input logic [7:0] c, input logic hb, input logic eos);
        run_tokens.delete();
        if (hb) scan_byte(c);
        if (eos) begin
            close_token();
            push_token(K_EOF, offset, 24'd0);
            clear_scanner();
        end
        if (run_tokens.size() > 0) run_tokens[run_tokens.size()-1].last = 1'b1;
        expected_tokens = {expected_tokens, run_tokens};
    endtask

    initial begin
        mismatches = 0;
        clear_scanner();
    end

    always @(posedge i_clk) begin
        t_token got, want;
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                got = '{i_token_kind, i_start_offset, i_span_length, i_line_number,
                        i_last_of_run};
                if (expected_tokens.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected token word: kind %0d start %0d span %0d",
                                 got.kind, got.start, got.span);
                end else begin
                    want = expected_tokens.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("Token mismatch: expected kind %0d start %0d span %0d",
                                     want.kind, want.start, want.span);
                            $display("  expected line %0d last %0d", want.line, want.last);
                            $display("  got kind %0d start %0d span %0d line %0d last %0d",
                                     got.kind, got.start, got.span, got.line, got.last);
                        end
                    end
                end
            end
            if (i_valid && !i_stall_in) predict_word(i_data_byte, i_has_byte, i_end_of_source);
        end
    end
endmodule
`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import sts_pkg::*;

    logic        clk, rst_n;
    logic        in_valid, in_stall;
    logic [7:0]  data_byte;
    logic        has_byte, end_of_source;
    logic        out_valid, out_stall;
    logic [5:0]  token_kind;
    logic [23:0] start_offset, span_length;
    logic [19:0] line_number;
    logic        last_of_run;
    int          fail_count, pending;
    int          words_sent;
    logic        quiet;
    logic        hold_output;
    logic        hold_done;

    sql_token_scanner DUT (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_data_byte(data_byte), .i_has_byte(has_byte), .i_end_of_source(end_of_source),
        .o_valid(out_valid), .i_stall(out_stall), .o_token_kind(token_kind),
        .o_start_offset(start_offset), .o_span_length(span_length),
        .o_line_number(line_number), .o_last_of_run(last_of_run)
    );

    sts_checker token_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_stall_in(in_stall),
        .i_data_byte(data_byte), .i_has_byte(has_byte), .i_end_of_source(end_of_source),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_token_kind(token_kind),
        .i_start_offset(start_offset), .i_span_length(span_length),
        .i_line_number(line_number), .i_last_of_run(last_of_run),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #2000000;
        $display("FAIL sql_token_scanner");
        $finish;
    end

    // Output stall: random bursts, one long hold once, none near the end.
    initial begin
        int n;
        out_stall = 1'b0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_output && !hold_done) begin
                out_stall <= 1'b1;
                repeat (60) @(negedge clk);
                out_stall <= 1'b0;
                hold_done = 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 12);
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Valid stays high after a word is taken, so that words can follow back to back;
    // the task drops it before its own random pauses, the caller before any other pause.
    task automatic send_word(input logic [7:0] c, input logic hb, input logic eos);
        int n;
        if (!quiet && $urandom_range(0, 6) == 0) begin
            n = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= c;
        has_byte <= hb;
        end_of_source <= eos;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        words_sent++;
    endtask

    task automatic send_text(input string s, input logic finish);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], 1'b1, finish && i == s.len() - 1);
    endtask

    function automatic logic [7:0] pick_byte();
        string alphabet;
        alphabet = "aZ_09.'\\\n -<>!=(),;+*xy";
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range(0, 255));
            default: return alphabet[$urandom_range(0, alphabet.len() - 1)];
        endcase
    endfunction

    initial begin
        string phrases[12];
        phrases = '{"select ", "CREATE ", "primary ", "VarChar ", "null ", "insert ",
                    "bigint ", "OR ", "'it\\'s' ", "12.75 ", "<= ", "-- note\n"};
        in_valid = 1'b0;
        data_byte = '0;
        has_byte = 1'b0;
        end_of_source = 1'b0;
        quiet = 1'b0;
        hold_output = 1'b0;
        words_sent = 0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: keywords, long words, operators, bytes above 127, odd endings.
        send_text("SELECT x_1,Varchar_long(12.5)", 1'b0);
        send_text("<><=>=!=!<>-+*;.\n", 1'b0);
        send_word(8'hFF, 1'b1, 1'b0);
        send_word(8'h80, 1'b1, 1'b0);
        send_word(8'h00, 1'b0, 1'b0);
        send_text("'a\\", 1'b1);
        send_text("x--c", 1'b1);
        send_word(8'h00, 1'b0, 1'b1);
        send_text("ab", 1'b0);
        send_word(8'h7F, 1'b0, 1'b1);

        // The sender waits until every expected token word has come.
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);

        // Single-byte operators after a word yield two tokens; the receiver starts its one long hold here.
        hold_output = 1'b1;
        send_text("a(b)c,d;e=f*g+h.k<", 1'b0);
        hold_output = 1'b0;

        for (int i = 0; i < 60; i++) begin
            if (i > 45) quiet = 1'b1;
            case ($urandom_range(0, 9))
                0, 1, 2, 3: send_text(phrases[$urandom_range(0, 11)], 1'b0);
                4: send_word(pick_byte(), 1'($urandom_range(0, 1)), 1'b1);
                5: send_word(pick_byte(), 1'b0, 1'b0);
                default: send_word(pick_byte(), 1'b1, 1'b0);
            endcase
        end
        send_word(8'h00, 1'b0, 1'b1);
        in_valid <= 1'b0;
        @(negedge clk);

        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS sql_token_scanner");
        else
            $display("FAIL sql_token_scanner");
        $finish;
    end
endmodule
`default_nettype wire
